// ===== rtl/record_bubble_sort_by_key_core_macros.svh =====
// assertion helpers for the sorter core rtl
`ifndef RECORD_BUBBLE_SORT_BY_KEY_CORE_MACROS_SVH
`define RECORD_BUBBLE_SORT_BY_KEY_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define RBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rbs_pkg;

    localparam int PRICE_W = 32;
    localparam int AREA_W  = 20;
    localparam int LOC_W   = 8;

    // one stored record, 61 bits
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [AREA_W-1:0]  area;
        logic               sold;
        logic [LOC_W-1:0]   location_id;
    } t_rec;

    // ordered pair out of the compare unit
    typedef struct packed {
        t_rec lo;
        t_rec hi;
    } t_pair;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_FIRST,
        S_CMP,
        S_TAIL,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/rbs_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbs_store
    import rbs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_rec          i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_rec               o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/rbs_swap.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbs_swap
    import rbs_pkg::*;
(
    input  wire t_rec i_early,
    input  wire t_rec i_late,
    output t_pair     o_pair
);

    // strict greater-than keeps equal keys in arrival order
    always_comb begin
        if (i_early.price > i_late.price) begin
            o_pair.lo = i_late;
            o_pair.hi = i_early;
        end else begin
            o_pair.lo = i_early;
            o_pair.hi = i_late;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/record_bubble_sort_by_key_core.sv =====
// Record sorter: records are loaded one per transfer into an internal store of
// DEPTH entries; a record with i_last_in set, or the record that fills the
// store, closes the set. The block then bubble-sorts the set ascending by
// price (equal prices keep arrival order) and sends every record out in
// sorted order, o_last_out marking the final one. A set of n records sorts
// in n-1 passes, each streaming the store through one compare-and-swap unit,
// one neighbor pair per cycle, limited by the single read and single write
// port of the store, plus pass setup and tail write. Each record is emitted
// through S_EMIT_RD, S_EMIT_LD and S_EMIT_WAIT, the last holding while
// i_stall is high. o_stall stays high from the closing transfer until the
// last sorted record has been taken.
`timescale 1ns / 1ps
`default_nettype none
`include "record_bubble_sort_by_key_core_macros.svh"

module record_bubble_sort_by_key_core
    import rbs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_price,
    input  wire logic [19:0] i_area,
    input  wire logic        i_sold,
    input  wire logic [7:0]  i_location_id,
    input  wire logic        i_last_in,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_out_price,
    output logic [19:0]      o_out_area,
    output logic             o_out_sold,
    output logic [7:0]       o_out_location_id,
    output logic             o_last_out
);

    localparam int AW = $clog2(DEPTH);

    // control state
    t_state          r_state, n_state;
    logic [AW-1:0]   r_count, n_count;     // records loaded so far into the set being loaded
    logic            r_out_valid, n_out_valid;

    // datapath registers
    logic [AW-1:0]   r_top, n_top;         // index of the last record of the set
    logic [AW-1:0]   r_lim, n_lim;         // last index of the current pass
    logic [AW-1:0]   r_pos, n_pos;         // write index within the pass
    logic [AW-1:0]   r_k, n_k;             // emission index
    t_rec            r_held, n_held;       // running largest record of the pass
    t_rec            r_out, n_out;
    logic            r_out_last, n_out_last;

    // store port and compare unit hookup
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    t_rec            w_wdata;
    logic [AW-1:0]   w_raddr;
    t_rec            w_rdata;
    t_rec            w_in_rec;
    t_pair           w_pair;
    logic            w_in_xfer;
    logic            w_out_xfer;
    logic [AW-1:0]   w_pos_inc;

    assign w_in_rec.price       = i_price;
    assign w_in_rec.area        = i_area;
    assign w_in_rec.sold        = i_sold;
    assign w_in_rec.location_id = i_location_id;

    assign o_stall    = (r_state != S_LOAD);
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = r_out_valid && !i_stall;
    assign w_pos_inc  = r_pos + AW'(1);

    rbs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // held record is the earlier one, freshly read record the later one
    rbs_swap u_swap (
        .i_early (r_held),
        .i_late  (w_rdata),
        .o_pair  (w_pair)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_lim      <= n_lim;
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_held     <= n_held;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_top       = r_top;
        n_lim       = r_lim;
        n_pos       = r_pos;
        n_k         = r_k;
        n_held      = r_held;
        n_out       = r_out;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_waddr     = r_count;
        w_wdata     = w_in_rec;
        w_raddr     = '0;

        unique case (r_state)
            S_LOAD: begin
                // store the record; the last one or the filling one closes the set
                if (w_in_xfer) begin
                    w_we    = 1'b1;
                    w_waddr = r_count;
                    w_wdata = w_in_rec;
                    if (i_last_in || (r_count == AW'(DEPTH - 1))) begin
                        n_top   = r_count;
                        n_lim   = r_count;
                        n_count = '0;
                        n_k     = '0;
                        n_state = (r_count == '0) ? S_EMIT_RD : S_PASS;
                    end else begin
                        n_count = r_count + AW'(1);
                    end
                end
            end
            S_PASS: begin
                // start a pass: fetch the first entry
                w_raddr = '0;
                n_pos   = '0;
                n_state = S_FIRST;
            end
            S_FIRST: begin
                n_held  = w_rdata;
                w_raddr = AW'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                // smaller goes down at pos, larger keeps bubbling up
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = w_pair.lo;
                n_held  = w_pair.hi;
                if (w_pos_inc == r_lim) begin
                    n_state = S_TAIL;
                end else begin
                    n_pos   = w_pos_inc;
                    w_raddr = r_pos + AW'(2);
                end
            end
            S_TAIL: begin
                // largest of the pass lands at the top of the unsorted part
                w_we    = 1'b1;
                w_waddr = r_lim;
                w_wdata = r_held;
                if (r_lim == AW'(1)) begin
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_lim   = r_lim - AW'(1);
                    n_state = S_PASS;
                end
            end
            S_EMIT_RD: begin
                w_raddr = r_k;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_out       = w_rdata;
                n_out_last  = (r_k == r_top);
                n_out_valid = 1'b1;
                n_state     = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                // wait for the output transfer
                if (w_out_xfer) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_out_price       = r_out.price;
    assign o_out_area        = r_out.area;
    assign o_out_sold        = r_out.sold;
    assign o_out_location_id = r_out.location_id;
    assign o_last_out        = r_out_last;

    // closing transfer with i_last_in makes the block busy on the next cycle
    `RBS_ASSERT_NEXT(a_close_busy, i_clk, i_rst_n,
        w_in_xfer && i_last_in, o_stall && !o_valid, "set closed but block not busy")

    // final record taken: block empty and loading again
    `RBS_ASSERT_NEXT(a_last_done, i_clk, i_rst_n,
        w_out_xfer && o_last_out, !o_stall && (r_count == '0), "not loading after last record")

    // compare step always stays inside the current pass
    `RBS_ASSERT_NOW(a_pos_in_pass, i_clk, i_rst_n,
        r_state == S_CMP, (r_pos < r_lim) && (r_lim <= r_top), "compare index outside pass")

    // output only presented while emitting, never while loading
    `RBS_ASSERT_NOW(a_valid_emit, i_clk, i_rst_n,
        o_valid, o_stall && (r_k <= r_top), "output valid outside emission")

endmodule

`default_nettype wire
